[rtl/tpmck_pkg.sv]
// ----------------------------------------------------------------------------
// tpmck_pkg
// shared types, codes and reset values for the trackpad-to-cursor-key block
// ----------------------------------------------------------------------------
package tpmck_pkg;

	localparam int DELTA_BITS     = 8;
	localparam int THR_BITS       = 10;
	localparam int TIMEOUT_BITS   = 16;
	localparam int KEY_BITS       = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam int ACCUM_BITS_DEF = 12;
	localparam int IDLE_BITS_DEF  = 16;

	// item kinds carried on tuser
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_MOTION = 1'b1;

	typedef enum logic [KEY_BITS-1:0] {
		CUR_NONE  = 3'd0,
		CUR_LEFT  = 3'd1,
		CUR_RIGHT = 3'd2,
		CUR_UP    = 3'd3,
		CUR_DOWN  = 3'd4
	} key_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_HORIZ = 2'd1,
		MODE_VERT  = 2'd2
	} mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_HORIZ_START  = 3'd0,
		CFG_HORIZ_REPEAT = 3'd1,
		CFG_VERT_START   = 3'd2,
		CFG_VERT_REPEAT  = 3'd3,
		CFG_IDLE_TIMEOUT = 3'd4
	} cfg_index_t;

	localparam logic [THR_BITS-1:0]     HORIZ_START_RST  = 10'd12;
	localparam logic [THR_BITS-1:0]     HORIZ_REPEAT_RST = 10'd6;
	localparam logic [THR_BITS-1:0]     VERT_START_RST   = 10'd20;
	localparam logic [THR_BITS-1:0]     VERT_REPEAT_RST  = 10'd10;
	localparam logic [TIMEOUT_BITS-1:0] IDLE_TIMEOUT_RST = 16'd400;

	typedef struct packed {
		logic [THR_BITS-1:0]     horiz_start;
		logic [THR_BITS-1:0]     horiz_repeat;
		logic [THR_BITS-1:0]     vert_start;
		logic [THR_BITS-1:0]     vert_repeat;
		logic [TIMEOUT_BITS-1:0] idle_timeout;
	} cfg_t;

	// outcome of one item, step logic to top level
	typedef struct packed {
		logic fire;
		key_t key;
	} step_res_t;

endpackage

[rtl/tpmck_step.sv]
// ----------------------------------------------------------------------------
// tpmck_step
// next-state logic for one item: idle timeout, saturating accumulate,
// horizontal then vertical threshold checks with axis hysteresis
// ----------------------------------------------------------------------------
module tpmck_step #(
	parameter int ACCUM_BITS = tpmck_pkg::ACCUM_BITS_DEF,
	parameter int IDLE_BITS  = tpmck_pkg::IDLE_BITS_DEF
) (
	input  tpmck_pkg::cfg_t                     cfg,
	input  logic                                op,
	input  logic [tpmck_pkg::DELTA_BITS-1:0]    delta_x,
	input  logic [tpmck_pkg::DELTA_BITS-1:0]    delta_y,
	input  logic [ACCUM_BITS-1:0]               accum_x,
	input  logic [ACCUM_BITS-1:0]               accum_y,
	input  tpmck_pkg::mode_t                    mode,
	input  logic [IDLE_BITS-1:0]                idle,
	output logic [ACCUM_BITS-1:0]               accum_x_nxt,
	output logic [ACCUM_BITS-1:0]               accum_y_nxt,
	output tpmck_pkg::mode_t                    mode_nxt,
	output logic [IDLE_BITS-1:0]                idle_nxt,
	output tpmck_pkg::step_res_t                res
);

	// compare width covers both the accumulator and a 10-bit threshold
	localparam int CW = ((ACCUM_BITS > tpmck_pkg::THR_BITS) ? ACCUM_BITS
		: tpmck_pkg::THR_BITS) + 2;
	localparam int TW = (IDLE_BITS > tpmck_pkg::TIMEOUT_BITS) ? IDLE_BITS
		: tpmck_pkg::TIMEOUT_BITS;
	localparam logic [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
	localparam logic [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

	logic                          timed_out;
	logic [ACCUM_BITS-1:0]         ax0, ay0;
	tpmck_pkg::mode_t              m0;
	logic [ACCUM_BITS:0]           sum_x, sum_y;
	logic [ACCUM_BITS-1:0]         ax1, ay1;
	logic signed [CW-1:0]          ax_e, ay_e, thr_x, thr_y;
	logic [ACCUM_BITS-1:0]         ax2, ay2, ax3, ay3;
	tpmck_pkg::mode_t              m2, m3;
	tpmck_pkg::key_t               key2, key3;
	logic [CW-1:0]                 ax_lo, ax_hi, ay_lo, ay_hi;

	assign timed_out = {{(TW-IDLE_BITS){1'b0}}, idle}
		> {{(TW-tpmck_pkg::TIMEOUT_BITS){1'b0}}, cfg.idle_timeout};

	assign ax0 = timed_out ? '0 : accum_x;
	assign ay0 = timed_out ? '0 : accum_y;
	assign m0  = timed_out ? tpmck_pkg::MODE_NONE : mode;

	// saturating add of the sign-extended deltas
	assign sum_x = {ax0[ACCUM_BITS-1], ax0}
		+ {{(ACCUM_BITS+1-tpmck_pkg::DELTA_BITS){delta_x[tpmck_pkg::DELTA_BITS-1]}}, delta_x};
	assign sum_y = {ay0[ACCUM_BITS-1], ay0}
		+ {{(ACCUM_BITS+1-tpmck_pkg::DELTA_BITS){delta_y[tpmck_pkg::DELTA_BITS-1]}}, delta_y};
	assign ax1 = (sum_x[ACCUM_BITS] != sum_x[ACCUM_BITS-1])
		? (sum_x[ACCUM_BITS] ? ACC_MIN : ACC_MAX) : sum_x[ACCUM_BITS-1:0];
	assign ay1 = (sum_y[ACCUM_BITS] != sum_y[ACCUM_BITS-1])
		? (sum_y[ACCUM_BITS] ? ACC_MIN : ACC_MAX) : sum_y[ACCUM_BITS-1:0];

	// horizontal check
	assign ax_e  = $signed({{(CW-ACCUM_BITS){ax1[ACCUM_BITS-1]}}, ax1});
	assign thr_x = $signed({{(CW-tpmck_pkg::THR_BITS){1'b0}},
		(m0 == tpmck_pkg::MODE_HORIZ) ? cfg.horiz_repeat : cfg.horiz_start});
	assign ax_lo = ax_e + thr_x;
	assign ax_hi = ax_e - thr_x;

	always_comb begin
		ax2  = ax1;
		ay2  = ay1;
		m2   = m0;
		key2 = tpmck_pkg::CUR_NONE;
		if (ax_e < -thr_x) begin
			ax2  = ax_lo[ACCUM_BITS-1:0];
			ay2  = '0;
			m2   = tpmck_pkg::MODE_HORIZ;
			key2 = tpmck_pkg::CUR_LEFT;
		end else if (ax_e > thr_x) begin
			ax2  = ax_hi[ACCUM_BITS-1:0];
			ay2  = '0;
			m2   = tpmck_pkg::MODE_HORIZ;
			key2 = tpmck_pkg::CUR_RIGHT;
		end
	end

	// vertical check, may replace the horizontal key
	assign ay_e  = $signed({{(CW-ACCUM_BITS){ay2[ACCUM_BITS-1]}}, ay2});
	assign thr_y = $signed({{(CW-tpmck_pkg::THR_BITS){1'b0}},
		(m2 == tpmck_pkg::MODE_VERT) ? cfg.vert_repeat : cfg.vert_start});
	assign ay_lo = ay_e + thr_y;
	assign ay_hi = ay_e - thr_y;

	always_comb begin
		ax3  = ax2;
		ay3  = ay2;
		m3   = m2;
		key3 = key2;
		if (ay_e < -thr_y) begin
			ay3  = ay_lo[ACCUM_BITS-1:0];
			ax3  = '0;
			m3   = tpmck_pkg::MODE_VERT;
			key3 = tpmck_pkg::CUR_UP;
		end else if (ay_e > thr_y) begin
			ay3  = ay_hi[ACCUM_BITS-1:0];
			ax3  = '0;
			m3   = tpmck_pkg::MODE_VERT;
			key3 = tpmck_pkg::CUR_DOWN;
		end
	end

	always_comb begin
		if (op == tpmck_pkg::OP_MOTION) begin
			accum_x_nxt = ax3;
			accum_y_nxt = ay3;
			mode_nxt    = m3;
			idle_nxt    = '0;
			res.fire    = (key3 != tpmck_pkg::CUR_NONE);
			res.key     = key3;
		end else begin
			accum_x_nxt = accum_x;
			accum_y_nxt = accum_y;
			mode_nxt    = mode;
			idle_nxt    = (idle == {IDLE_BITS{1'b1}}) ? idle : idle + 1'b1;
			res.fire    = 1'b0;
			res.key     = tpmck_pkg::CUR_NONE;
		end
	end

endmodule

[rtl/trackpad_motion_to_cursor_keys.sv]
// ----------------------------------------------------------------------------
// trackpad_motion_to_cursor_keys
// turns relative trackpad motion and idle ticks into cursor key events
// ----------------------------------------------------------------------------
// One item is taken per clock while the output register is free or being
// drained. An accepted item is held in the input register, where the step
// logic (idle timeout, saturating add, horizontal then vertical threshold
// check) runs against the live state; when it retires, the state is updated
// and a fired key, if any, lands in the output register, from which it is
// offered; while that register holds an undrained key, the item waits.
// The sustained rate is one item per cycle while the output is not stalled,
// set by the state update loop through the step logic. Ticks and motion
// that fires no key give no output transfer. Configuration writes are taken
// at any time and belong to idle periods; cfg_ready is always high.
// ----------------------------------------------------------------------------
module trackpad_motion_to_cursor_keys #(
	parameter int ACCUM_BITS = tpmck_pkg::ACCUM_BITS_DEF,
	parameter int IDLE_BITS  = tpmck_pkg::IDLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,  // delta_x [7:0], delta_y [15:8]
	input  logic                                  s_tuser,  // op (0 tick, 1 motion)
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // cursor_key [2:0], zero fill
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tpmck_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tpmck_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int DB = tpmck_pkg::DELTA_BITS;

	// configuration registers
	tpmck_pkg::cfg_t cfg_q;

	// input register
	logic            s1_valid;
	logic            s1_op;
	logic [DB-1:0]   s1_dx;
	logic [DB-1:0]   s1_dy;

	// block state
	logic [ACCUM_BITS-1:0] accum_x_q, accum_y_q;
	tpmck_pkg::mode_t      mode_q;
	logic [IDLE_BITS-1:0]  idle_q;

	// output register
	logic                  m_valid_q;
	tpmck_pkg::key_t       key_q;

	// step logic outputs
	logic [ACCUM_BITS-1:0] accum_x_nxt, accum_y_nxt;
	tpmck_pkg::mode_t      mode_nxt;
	logic [IDLE_BITS-1:0]  idle_nxt;
	tpmck_pkg::step_res_t  res;

	logic out_free;
	logic adv;

	// output slot is free when empty or being drained this cycle
	assign out_free = !m_valid_q || m_tready;
	// item in the input register retires into state and output
	assign adv      = s1_valid && out_free;
	assign s_tready = !s1_valid || adv;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(8-tpmck_pkg::KEY_BITS){1'b0}}, key_q};

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horiz_start  <= tpmck_pkg::HORIZ_START_RST;
			cfg_q.horiz_repeat <= tpmck_pkg::HORIZ_REPEAT_RST;
			cfg_q.vert_start   <= tpmck_pkg::VERT_START_RST;
			cfg_q.vert_repeat  <= tpmck_pkg::VERT_REPEAT_RST;
			cfg_q.idle_timeout <= tpmck_pkg::IDLE_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (tpmck_pkg::cfg_index_t'(cfg_index))
				tpmck_pkg::CFG_HORIZ_START: begin
					cfg_q.horiz_start <= cfg_data[tpmck_pkg::THR_BITS-1:0];
				end
				tpmck_pkg::CFG_HORIZ_REPEAT: begin
					cfg_q.horiz_repeat <= cfg_data[tpmck_pkg::THR_BITS-1:0];
				end
				tpmck_pkg::CFG_VERT_START: begin
					cfg_q.vert_start <= cfg_data[tpmck_pkg::THR_BITS-1:0];
				end
				tpmck_pkg::CFG_VERT_REPEAT: begin
					cfg_q.vert_repeat <= cfg_data[tpmck_pkg::THR_BITS-1:0];
				end
				tpmck_pkg::CFG_IDLE_TIMEOUT: begin
					cfg_q.idle_timeout <= cfg_data[tpmck_pkg::TIMEOUT_BITS-1:0];
				end
				default: begin
					// unknown index, write ignored
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_op <= s_tuser;
			s1_dx <= s_tdata[DB-1:0];
			s1_dy <= s_tdata[2*DB-1:DB];
		end
	end

	tpmck_step #(
		.ACCUM_BITS (ACCUM_BITS),
		.IDLE_BITS  (IDLE_BITS)
	) u_step (
		.cfg         (cfg_q),
		.op          (s1_op),
		.delta_x     (s1_dx),
		.delta_y     (s1_dy),
		.accum_x     (accum_x_q),
		.accum_y     (accum_y_q),
		.mode        (mode_q),
		.idle        (idle_q),
		.accum_x_nxt (accum_x_nxt),
		.accum_y_nxt (accum_y_nxt),
		.mode_nxt    (mode_nxt),
		.idle_nxt    (idle_nxt),
		.res         (res)
	);

	// state update, idle count starts saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_x_q <= '0;
			accum_y_q <= '0;
			mode_q    <= tpmck_pkg::MODE_NONE;
			idle_q    <= '1;
		end else if (adv) begin
			accum_x_q <= accum_x_nxt;
			accum_y_q <= accum_y_nxt;
			mode_q    <= mode_nxt;
			idle_q    <= idle_nxt;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= res.fire;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv && res.fire) begin
			key_q <= res.key;
		end
	end

	// a delivered key is always one of the four directions
	a_key_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (key_q == tpmck_pkg::CUR_LEFT || key_q == tpmck_pkg::CUR_RIGHT
			|| key_q == tpmck_pkg::CUR_UP || key_q == tpmck_pkg::CUR_DOWN))
		else $error("output key out of range");

	// a retired motion restarts the idle count
	a_idle_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_op == tpmck_pkg::OP_MOTION) |=> (idle_q == '0))
		else $error("idle count not cleared by motion");

	// a horizontal key leaves the vertical accumulator cleared
	a_horiz_clears_y: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.fire && (res.key == tpmck_pkg::CUR_LEFT
			|| res.key == tpmck_pkg::CUR_RIGHT)) |=> (accum_y_q == '0))
		else $error("vertical accumulator kept after horizontal key");

	// a stalled item in the input register is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !adv) |=> (s1_valid && $stable(s1_op) && $stable(s1_dx)
			&& $stable(s1_dy)))
		else $error("input register lost a stalled item");

endmodule
